[rtl/core/espk_pkg.sv]
package espk_pkg;

    // Default packet size in bytes
    localparam int PACKET_BYTES_DEF = 64;

    // Prefix codes on the wire
    localparam logic [7:0] CODE_ESC = 8'hF0;
    localparam logic [7:0] CODE_EOI = 8'hF1;

    // Result slots of one request, in wire order
    localparam int SLOT_PRE  = 0;   // boundary before the request
    localparam int SLOT_PFX  = 1;   // escape or EOI prefix
    localparam int SLOT_DAT  = 2;   // the data byte itself
    localparam int SLOT_POST = 3;   // boundary after the final byte
    localparam int NUM_SLOTS = 4;

    // One accepted input request
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       eoi;
    } t_item;

    // Encoded results of one request, still to be sent
    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic [7:0]           prefix;
        logic [7:0]           data;
    } t_plan;

    // One result on the output side
    typedef struct packed {
        logic [7:0] out_byte;
        logic       close;
        logic       payload;
        logic       last;
    } t_result;

endpackage

[rtl/core/espk_encode.sv]
module espk_encode #(
    parameter int PACKET_BYTES = espk_pkg::PACKET_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  espk_pkg::t_item  i_item,
    input  logic             i_take,
    output espk_pkg::t_plan  o_plan
);

    localparam int FW = $clog2(PACKET_BYTES + 1);

    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic          mark_eoi;
    logic          esc;
    logic          pair;
    logic [FW:0]   need;
    logic [FW:0]   sum;
    logic          pre_close;

    // Classify the byte and work out how many wire bytes it takes
    always_comb begin
        mark_eoi  = i_item.fin && i_item.eoi;
        esc       = (i_item.data == espk_pkg::CODE_ESC) || (i_item.data == espk_pkg::CODE_EOI);
        pair      = mark_eoi || esc;
        need      = pair ? (FW+1)'(2) : (FW+1)'(1);
        sum       = {1'b0, r_fill} + need;
        pre_close = sum > (FW+1)'(PACKET_BYTES);
    end

    // Build the list of results for this request
    always_comb begin
        o_plan                           = '0;
        o_plan.slots[espk_pkg::SLOT_PRE]  = pre_close;
        o_plan.slots[espk_pkg::SLOT_PFX]  = pair;
        o_plan.slots[espk_pkg::SLOT_DAT]  = 1'b1;
        o_plan.slots[espk_pkg::SLOT_POST] = i_item.fin;
        o_plan.prefix = mark_eoi ? espk_pkg::CODE_EOI : espk_pkg::CODE_ESC;
        o_plan.data   = i_item.data;
    end

    // Advance the packet fill level
    always_comb begin
        n_fill = r_fill;
        if (i_take) begin
            if (i_item.fin) begin
                n_fill = '0;
            end else if (pre_close) begin
                n_fill = need[FW-1:0];
            end else begin
                n_fill = sum[FW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Fill level stays within one packet
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_fill} <= (FW+1)'(PACKET_BYTES))
        else $error("packet fill beyond packet size");

    // A final byte leaves an empty packet behind
    a_fin_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_item.fin |=> r_fill == '0)
        else $error("packet not emptied after final byte");

endmodule

[rtl/core/espk_emit.sv]
module espk_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  espk_pkg::t_plan    i_plan,
    output logic               o_ready,
    output logic               o_out_valid,
    output espk_pkg::t_result  o_out,
    input  logic               i_out_ready
);

    logic [espk_pkg::NUM_SLOTS-1:0] r_slots;
    logic [espk_pkg::NUM_SLOTS-1:0] n_slots;
    logic [espk_pkg::NUM_SLOTS-1:0] first;
    logic [7:0]                     r_prefix;
    logic [7:0]                     r_data;
    logic                           r_post;
    logic                           r_out_valid;
    espk_pkg::t_result              r_out;
    espk_pkg::t_result              n_out;
    logic                           mv;
    logic                           pop;
    logic                           single;

    // Pick the earliest pending slot
    always_comb begin
        mv      = !r_out_valid || i_out_ready;
        pop     = mv && (r_slots != '0);
        first   = r_slots & (~r_slots + 1'b1);
        single  = (r_slots & (r_slots - 1'b1)) == '0;
        o_ready = (r_slots == '0) || (pop && single);
    end

    // Form the result of the chosen slot
    always_comb begin
        n_out = '0;
        if (first[espk_pkg::SLOT_PRE]) begin
            n_out.close = 1'b1;
        end else if (first[espk_pkg::SLOT_PFX]) begin
            n_out.out_byte = r_prefix;
        end else if (first[espk_pkg::SLOT_DAT]) begin
            n_out.out_byte = r_data;
            n_out.payload  = 1'b1;
            n_out.last     = !r_post;
        end else begin
            n_out.close = 1'b1;
            n_out.last  = 1'b1;
        end
    end

    // Drop sent slots, load the next request
    always_comb begin
        n_slots = r_slots;
        if (i_load) begin
            n_slots = i_plan.slots;
        end else if (pop) begin
            n_slots = r_slots & ~first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_slots <= n_slots;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prefix <= i_plan.prefix;
            r_data   <= i_plan.data;
            r_post   <= i_plan.slots[espk_pkg::SLOT_POST];
        end
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A new request never overwrites slots still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_slots == '0) || (pop && single))
        else $error("request loaded over pending results");

    // Every loaded request carries its data byte
    a_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> i_plan.slots[espk_pkg::SLOT_DAT])
        else $error("request without data slot");

endmodule

[rtl/core/escape_stuffing_packetizer_top.sv]
// Byte-stuffing escape encoder with packet framing. Each input request carries
// one data byte (tdata), the last-byte-of-write flag (tlast) and end-with-EOI
// (tuser). Bytes 0xF0 and 0xF1 go out as 0xF0 followed by the byte; a final
// byte with end-with-EOI goes out as 0xF1 followed by the byte. Bytes are packed
// into packets of at most PACKET_BYTES; a boundary result (tuser[0] high, tdata
// zero) closes a packet before a byte or pair that would not fit, and after
// every final byte. tlast marks the last result of each input request. One
// result leaves per cycle while the output is ready; a request produces one to
// four results, and the input register takes a new request as soon as the
// emitter starts the last result of the previous.
module escape_stuffing_packetizer_top #(
    parameter int PACKET_BYTES = espk_pkg::PACKET_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // final_byte
    input  logic       i_s_tuser,   // end_with_eoi
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_tuser,   // [0] packet_close, [1] is_payload
    output logic       o_m_tlast    // run_last
);

    logic               r_in_valid;
    espk_pkg::t_item    r_in;
    logic               take;
    logic               emit_ready;
    espk_pkg::t_plan    plan;
    espk_pkg::t_result  res;

    // Hand the held request to the emitter when it can take it
    assign take       = r_in_valid && emit_ready;
    assign o_s_tready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.data <= i_s_tdata;
            r_in.fin  <= i_s_tlast;
            r_in.eoi  <= i_s_tuser;
        end
    end

    espk_encode #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_encode (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (r_in),
        .i_take (take),
        .o_plan (plan)
    );

    espk_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_plan     (plan),
        .o_ready    (emit_ready),
        .o_out_valid(o_m_tvalid),
        .o_out      (res),
        .i_out_ready(i_m_tready)
    );

    assign o_m_tdata = res.out_byte;
    assign o_m_tuser = {res.payload, res.close};
    assign o_m_tlast = res.last;

endmodule
